### hdl/sliding_window_mean_max_macros.svh
// ----------------------------------------------------------------------------
// sliding_window_mean_max_macros
// Assertion helpers shared by the window block.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEAN_MAX_MACROS_SVH
`define SLIDING_WINDOW_MEAN_MAX_MACROS_SVH

// same-cycle implication, disabled in reset
`define SWMM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SWMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared widths, defaults and types of the sliding window mean/max block.
// ----------------------------------------------------------------------------
package swmm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int QUO_W      = 16;
    localparam int DEF_WINDOW = 60;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } t_state;

endpackage

### hdl/sliding_window_mean_max.sv
// An accepted sample shifts into the WINDOW-long cell chain; its result is registered
// once the peak sweep has settled. No new sample is taken before that, and a held prior
// result can delay the finish; the peak ripples one cell a cycle down the chain and sets
// the pace, the mean comes through the registered total and the divider's quotient register.
// A finished result waits in the output register while the next sample is taken.
// Reset (synchronous, active low) zeroes every window cell and the running total.
// ----------------------------------------------------------------------------
// sliding_window_mean_max
// Sliding window of power samples: truncated mean and peak of the last WINDOW.
// ----------------------------------------------------------------------------
`include "sliding_window_mean_max_macros.svh"

module sliding_window_mean_max #(
    parameter int WINDOW = swmm_pkg::DEF_WINDOW
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample request
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [swmm_pkg::SAMPLE_W-1:0]   i_s_axis_tdata,  // [15:0] sample
    // result request
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [2*swmm_pkg::SAMPLE_W-1:0] o_m_axis_tdata   // [15:0] window_mean,
                                                             // [31:16] window_peak
);
    import swmm_pkg::*;

    localparam int TW       = SAMPLE_W + $clog2(WINDOW);
    localparam int CW       = $clog2(WINDOW + 1);
    localparam logic [CW-1:0]  DONE_CNT  = CW'(WINDOW);
    localparam logic [TW+SAMPLE_W-1:0] TOTAL_MAX =
        (TW+SAMPLE_W)'(WINDOW) * (TW+SAMPLE_W)'((1 << SAMPLE_W) - 1);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [TW-1:0]     r_total, n_total;
    logic              r_ovalid, n_ovalid;
    logic [SAMPLE_W-1:0] r_mean, r_peak;
    logic              w_accept;
    logic              w_finish;
    logic [QUO_W-1:0]  w_quotient;

    // window chain: entry 0 is the oldest, WINDOW-1 the newest
    logic [SAMPLE_W-1:0] w_data [WINDOW];
    logic [SAMPLE_W-1:0] w_pmax [WINDOW];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // result leaves once the peak sweep has settled (the mean is ready
    // long before), and only when the output register is free or draining
    assign w_finish = (r_state == ST_BUSY) && (r_cnt == DONE_CNT)
                   && (!r_ovalid || i_m_axis_tready);

    // Each cell shifts toward the old end on accept; the partial peak
    // moves one cell per cycle from the oldest end to the newest.
    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        logic [SAMPLE_W-1:0] w_in_data;
        logic [SAMPLE_W-1:0] w_in_pmax;
        if (k == WINDOW - 1) begin : g_head
            assign w_in_data = i_s_axis_tdata;
        end else begin : g_body
            assign w_in_data = w_data[k+1];
        end
        if (k == 0) begin : g_first
            assign w_in_pmax = '0;
        end else begin : g_rest
            assign w_in_pmax = w_pmax[k-1];
        end
        swmm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_data  (w_in_data),
            .i_pmax  (w_in_pmax),
            .o_data  (w_data[k]),
            .o_pmax  (w_pmax[k])
        );
    end

    // running total: drop the oldest, add the newest
    assign n_total = r_total - TW'(w_data[0]) + TW'(i_s_axis_tdata);

    // mean from the registered total, through the divider's quotient register
    swmm_div #(
        .WINDOW (WINDOW)
    ) u_div (
        .i_clk      (i_clk),
        .i_dividend (r_total),
        .o_quotient (w_quotient)
    );

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid;
        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_BUSY;
                    n_cnt   = '0;
                end
            end
            ST_BUSY: begin
                if (r_cnt != DONE_CNT) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (w_finish) begin
                    n_state  = ST_IDLE;
                    n_ovalid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            if (w_accept) begin
                r_total <= n_total;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_mean <= w_quotient;
            r_peak <= w_pmax[WINDOW-1];
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_peak, r_mean};

    `SWMM_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept, (r_state == ST_BUSY) && (r_cnt == '0), "accepted sample did not start a sweep")
    `SWMM_ASSERT_NOW(a_finish_settled, i_clk, i_rst_n, w_finish, r_cnt == DONE_CNT, "result taken before sweep settled")
    `SWMM_ASSERT_NEXT(a_finish_valid, i_clk, i_rst_n, w_finish, o_m_axis_tvalid && (r_state == ST_IDLE), "finished result not presented")
    `SWMM_ASSERT_NOW(a_total_bound, i_clk, i_rst_n, 1'b1, (TW+SAMPLE_W)'(r_total) <= TOTAL_MAX, "running total exceeds window bound")

endmodule

### hdl/swmm_cell.sv
// ----------------------------------------------------------------------------
// swmm_cell
// One window slot: holds a sample and folds it into the running peak.
// ----------------------------------------------------------------------------
module swmm_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic [swmm_pkg::SAMPLE_W-1:0] i_data,
    input  logic [swmm_pkg::SAMPLE_W-1:0] i_pmax,
    output logic [swmm_pkg::SAMPLE_W-1:0] o_data,
    output logic [swmm_pkg::SAMPLE_W-1:0] o_pmax
);
    import swmm_pkg::*;

    logic [SAMPLE_W-1:0] r_data, n_data;
    logic [SAMPLE_W-1:0] r_pmax, n_pmax;

    always_comb begin
        n_data = i_shift ? i_data : r_data;
        n_pmax = (r_data > i_pmax) ? r_data : i_pmax;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
            r_pmax <= '0;
        end else begin
            r_data <= n_data;
            r_pmax <= n_pmax;
        end
    end

    assign o_data = r_data;
    assign o_pmax = r_pmax;

endmodule

### hdl/swmm_div.sv
// ----------------------------------------------------------------------------
// swmm_div
// Window total divided by WINDOW through a fixed reciprocal, registered.
// ----------------------------------------------------------------------------
module swmm_div #(
    parameter int WINDOW = swmm_pkg::DEF_WINDOW
) (
    input  logic                                         i_clk,
    input  logic [swmm_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] i_dividend,
    output logic [swmm_pkg::QUO_W-1:0]                   o_quotient
);
    import swmm_pkg::*;

    // q = (n * ceil(2^SH / WINDOW)) >> SH is exact for every n below 2^TW
    // when SH = TW + ceil(log2(WINDOW)); the reciprocal fits TW+1 bits
    localparam int TW = SAMPLE_W + $clog2(WINDOW);
    localparam int SH = TW + $clog2(WINDOW);
    localparam int MW = TW + 1;
    localparam int PW = TW + MW;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_WIDE);

    logic [PW-1:0]    w_prod;
    logic [QUO_W-1:0] r_quo;

    // TW x MW bit product (22 x 23 at the default window)
    assign w_prod = PW'(i_dividend) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        r_quo <= w_prod[SH +: QUO_W];
    end

    assign o_quotient = r_quo;

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sliding_window_mean_max: sends power samples, keeps
// its own copy of the 60-entry window and running total, and compares the
// mean and peak of every result request against that copy.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swmm_pkg::*;

    localparam int WINDOW_LEN = DEF_WINDOW;
    // slowest run: ~1100 samples, each with the longest idle gap, a full peak sweep and
    // the longest output stall; taken several times over
    localparam int RUN_LIMIT  = 500000;

    // expected content of one result request, peak above mean as on the bus
    typedef struct packed {
        logic [SAMPLE_W-1:0] peak;
        logic [SAMPLE_W-1:0] mean;
    } window_stat_t;

    // ------------------------------------------------------------------------
    // clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------------
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [SAMPLE_W-1:0]   i_s_axis_tdata  = '0;  // [15:0] sample
    logic                  i_m_axis_tready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [2*SAMPLE_W-1:0] o_m_axis_tdata;        // [15:0] window_mean, [31:16] window_peak

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sliding_window_mean_max #(
        .WINDOW(WINDOW_LEN)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // window predictor: entry 0 oldest, entry WINDOW_LEN-1 newest
    // ------------------------------------------------------------------------
    logic [SAMPLE_W-1:0] window_cells [WINDOW_LEN];
    logic [31:0]         window_sum;        // wide enough never to wrap
    window_stat_t        pending_stats [$]; // one per accepted sample, oldest first

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    bit          idling_on      = 1'b1;     // random gaps on both sides

    // shift one sample in, drop the oldest, return mean and peak afterwards
    function automatic window_stat_t shift_in_sample(logic [SAMPLE_W-1:0] fresh);
        window_stat_t stat;
        logic [SAMPLE_W-1:0] oldest;
        oldest = window_cells[0];
        for (int k = 0; k + 1 < WINDOW_LEN; k++)
            window_cells[k] = window_cells[k + 1];
        window_cells[WINDOW_LEN - 1] = fresh;
        window_sum = window_sum - 32'(oldest) + 32'(fresh);
        stat.mean = SAMPLE_W'(window_sum / WINDOW_LEN);
        stat.peak = '0;  // cleared cells count as zeros, so the peak floors at 0
        for (int k = 0; k < WINDOW_LEN; k++)
            if (window_cells[k] > stat.peak)
                stat.peak = window_cells[k];
        return stat;
    endfunction

    // ------------------------------------------------------------------------
    // sample request: optional idle burst, then hold tvalid until accepted.
    // Called at a rising edge; returns at the edge that took the sample.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        @(posedge i_clk);
        // values read here are the ones the block saw at this edge
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_stats.push_back(shift_in_sample(value));
    endtask

    // ------------------------------------------------------------------------
    // result side: random stall bursts on tready, check every result request
    // ------------------------------------------------------------------------
    int unsigned stall_left = 0;

    always @(posedge i_clk) begin
        window_stat_t want;
        window_stat_t got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (pending_stats.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, actual mean %0d peak %0d",
                         $time, got.mean, got.peak);
            end else begin
                want = pending_stats.pop_front();
                if (got.mean !== want.mean) begin
                    mismatch_count++;
                    $display("%0t: window_mean mismatch: expected %0d, actual %0d",
                             $time, want.mean, got.mean);
                end
                if (got.peak !== want.peak) begin
                    mismatch_count++;
                    $display("%0t: window_peak mismatch: expected %0d, actual %0d",
                             $time, want.peak, got.peak);
                end
            end
        end
        // random stall bursts, none once idling is switched off
        if (stall_left > 0)
            stall_left--;
        else if (idling_on && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 17);
        i_m_axis_tready <= i_rst_n && (stall_left == 0);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("** sliding_window_mean_max: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // first samples after reset: the zero-filled window dilutes the mean,
    // plus field extremes and alternating bit patterns
    task automatic test_partly_filled_window();
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'h0000);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'hAAAA);
        send_sample(16'h5555);
        send_sample(16'hFFFF);
        send_sample(16'hFFFE);
        send_sample(16'h00FF);
        send_sample(16'hFF00);
    endtask

    // uniform random samples, occasionally pinned to an extreme or drawn from 0..15
    task automatic test_random_samples(input int unsigned count);
        logic [SAMPLE_W-1:0] value;
        for (int unsigned n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0:       value = 16'hFFFF;
                1:       value = 16'h0000;
                2:       value = SAMPLE_W'($urandom_range(0, 15));
                default: value = SAMPLE_W'($urandom);
            endcase
            send_sample(value);
        end
    endtask

    // shaped runs that walk the window through whole turnovers: flat levels
    // (a full window of 65535 drives the mean to its top), falling ramps so
    // the peak retires as the oldest cell leaves, and lone spikes among values of 0..3
    task automatic test_window_runs(input int unsigned count);
        int unsigned         sent;
        int unsigned         run_len;
        int unsigned         fall;
        logic [SAMPLE_W-1:0] level;
        sent = 0;
        while (sent < count) begin
            run_len = WINDOW_LEN + $urandom_range(0, 10);
            level   = ($urandom_range(0, 2) == 0) ? 16'hFFFF : SAMPLE_W'($urandom);
            case ($urandom_range(0, 2))
                0: begin
                    for (int unsigned k = 0; k < run_len; k++)
                        send_sample(level);
                end
                1: begin
                    fall = $urandom_range(1, 1200);
                    for (int unsigned k = 0; k < run_len; k++) begin
                        send_sample(level);
                        level = (level > fall) ? level - SAMPLE_W'(fall) : '0;
                    end
                end
                default: begin
                    send_sample(level);
                    for (int unsigned k = 1; k < run_len; k++)
                        send_sample(SAMPLE_W'($urandom_range(0, 3)));
                end
            endcase
            sent += run_len;
        end
    endtask

    // closing stretch with no idling on either side
    task automatic test_back_to_back(input int unsigned count);
        idling_on = 1'b0;
        test_random_samples(count);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int k = 0; k < WINDOW_LEN; k++)
            window_cells[k] = '0;
        window_sum = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_partly_filled_window();
        test_random_samples(350);
        test_window_runs(450);
        test_back_to_back(200);

        i_s_axis_tvalid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (2 * WINDOW_LEN) @(posedge i_clk);

        if (mismatch_count == 0 && pending_stats.size() == 0)
            $display("** sliding_window_mean_max: PASSED **");
        else
            $display("** sliding_window_mean_max: FAILED **");
        $finish;
    end

endmodule
